// ===== hw/rtl/hs_pkg.sv =====
// Shared types and constants of the heap sorter.
package hs_pkg;

  // Width of the value fields on the request channels.
  localparam int PORT_BITS = 32;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_BUILD_INIT,
    OP_BUILD_NODE,
    OP_TAKE_CUR,
    OP_SIFT_RD,
    OP_SIFT_STEP,
    OP_EXT_INIT,
    OP_EXT_RD,
    OP_EXT_WR,
    OP_OUT_INIT,
    OP_OUT_RD,
    OP_OUT_LD
  } hs_op_t;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic count_small;  // fewer than two values stored
    logic i_zero;       // loop counter has reached zero
    logic sift_done;    // no child beats the value being sifted
    logic out_free;     // output register can take a result
    logic out_final;    // the result being read is the last of the run
  } hs_status_t;

endpackage

// ===== hw/rtl/hs_in_if.sv =====
// Input request channel: value and last marker.
interface hs_in_if import hs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PORT_BITS-1:0] in_value;
  logic                 in_last;

  modport source (output valid, in_value, in_last, input ready);
  modport sink   (input valid, in_value, in_last, output ready);
endinterface

// ===== hw/rtl/hs_out_if.sv =====
// Result request channel: sorted value, last marker and overflow flag.
interface hs_out_if import hs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PORT_BITS-1:0] out_value;
  logic                 out_last;
  logic                 out_overflow;

  modport source (output valid, out_value, out_last, out_overflow, input ready);
  modport sink   (input valid, out_value, out_last, out_overflow, output ready);
endinterface

// ===== hw/rtl/hs_ctrl.sv =====
// Heap sorter controller: sequences load, heap build, extraction and readout.
module hs_ctrl import hs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_ready,
  input  hs_status_t status,
  output hs_op_t     op
);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT,
    ST_BUILD_NEXT,
    ST_SIFT_CUR,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_EXT_START,
    ST_EXT_RD,
    ST_EXT_WR,
    ST_OUT_INIT,
    ST_OUT_RD,
    ST_OUT_LD
  } state_t;

  state_t state_r, state_nxt;
  logic   extract_r, extract_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    state_nxt   = state_r;
    extract_nxt = extract_r;
    op          = OP_NONE;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid && in_ready_r) begin
          op = OP_LOAD;
          if (in_last) begin
            state_nxt = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        if (status.count_small) begin
          state_nxt = ST_OUT_INIT;
        end else begin
          op          = OP_BUILD_INIT;
          extract_nxt = 1'b0;
          state_nxt   = ST_BUILD_NEXT;
        end
      end
      ST_BUILD_NEXT: begin
        op        = OP_BUILD_NODE;
        state_nxt = ST_SIFT_CUR;
      end
      ST_SIFT_CUR: begin
        op        = OP_TAKE_CUR;
        state_nxt = ST_SIFT_RD;
      end
      ST_SIFT_RD: begin
        op        = OP_SIFT_RD;
        state_nxt = ST_SIFT_CMP;
      end
      ST_SIFT_CMP: begin
        op = OP_SIFT_STEP;
        if (!status.sift_done) begin
          state_nxt = ST_SIFT_RD;
        end else if (status.i_zero) begin
          state_nxt = extract_r ? ST_OUT_INIT : ST_EXT_START;
        end else begin
          state_nxt = extract_r ? ST_EXT_RD : ST_BUILD_NEXT;
        end
      end
      ST_EXT_START: begin
        op          = OP_EXT_INIT;
        extract_nxt = 1'b1;
        state_nxt   = ST_EXT_RD;
      end
      ST_EXT_RD: begin
        op        = OP_EXT_RD;
        state_nxt = ST_EXT_WR;
      end
      ST_EXT_WR: begin
        op        = OP_EXT_WR;
        state_nxt = ST_SIFT_RD;
      end
      ST_OUT_INIT: begin
        op        = OP_OUT_INIT;
        state_nxt = ST_OUT_RD;
      end
      ST_OUT_RD: begin
        op        = OP_OUT_RD;
        state_nxt = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        if (status.out_free) begin
          op        = OP_OUT_LD;
          state_nxt = status.out_final ? ST_LOAD : ST_OUT_RD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      extract_r  <= 1'b0;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      extract_r  <= extract_nxt;
      in_ready_r <= (state_nxt == ST_LOAD);
    end
  end

endmodule

// ===== hw/rtl/hs_datapath.sv =====
// Heap sorter datapath: value store, sift-down compare, counters and output register.
module hs_datapath import hs_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hs_op_t               op,
  input  logic [PORT_BITS-1:0] in_value,
  input  logic                 out_ready,
  output hs_status_t           status,
  output logic                 out_valid,
  output logic [PORT_BITS-1:0] out_value,
  output logic                 out_last,
  output logic                 out_overflow
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = IW + 2;

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rda_r, rdb_r;

  logic [CW-1:0]         count_r;
  logic                  ovf_r;
  logic [CW-1:0]         i_r;
  logic [IW-1:0]         node_r;
  logic [CW-1:0]         live_r;
  logic [VALUE_BITS-1:0] cur_r;

  logic                  out_valid_r;
  logic [PORT_BITS-1:0]  out_value_r;
  logic                  out_last_r;
  logic                  out_ovf_r;

  logic [VALUE_BITS-1:0] in_ext;
  logic [PORT_BITS-1:0]  out_conv;

  // Fit the port value to the stored width and back.
  if (VALUE_BITS <= PORT_BITS) begin : g_in_narrow
    assign in_ext = in_value[VALUE_BITS-1:0];
  end else begin : g_in_wide
    assign in_ext = {{(VALUE_BITS-PORT_BITS){1'b0}}, in_value};
  end
  if (VALUE_BITS >= PORT_BITS) begin : g_out_wide
    assign out_conv = rda_r[PORT_BITS-1:0];
  end else begin : g_out_narrow
    assign out_conv = {{(PORT_BITS-VALUE_BITS){1'b0}}, rda_r};
  end

  // Child indices of the current node and their bounds against the live heap.
  logic [KW-1:0] left_idx, right_idx, live_ext;
  logic          left_in, right_in;
  logic          sel_l, sel_r;
  logic [VALUE_BITS-1:0] big_l;
  logic [CW-1:0] i_dec;
  logic          room;

  assign left_idx  = {1'b0, node_r, 1'b1};
  assign right_idx = left_idx + KW'(1);
  assign live_ext  = {{(KW-CW){1'b0}}, live_r};
  assign left_in   = left_idx < live_ext;
  assign right_in  = right_idx < live_ext;
  assign sel_l     = left_in && (rda_r > cur_r);
  assign big_l     = sel_l ? rda_r : cur_r;
  assign sel_r     = right_in && (rdb_r > big_l);
  assign i_dec     = i_r - CW'(1);
  assign room      = count_r < CW'(DEPTH);

  assign status.count_small = count_r < CW'(2);
  assign status.i_zero      = (i_r == '0);
  assign status.sift_done   = !(sel_l || sel_r);
  assign status.out_free    = !out_valid_r || out_ready;
  assign status.out_final   = ((i_r + CW'(1)) == count_r);

  // Memory port selection.
  logic                  we, rea, reb;
  logic [IW-1:0]         waddr, raddr_a, raddr_b;
  logic [VALUE_BITS-1:0] wdata;

  always_comb begin
    we      = 1'b0;
    waddr   = '0;
    wdata   = cur_r;
    rea     = 1'b0;
    raddr_a = '0;
    reb     = 1'b0;
    raddr_b = '0;
    unique case (op)
      OP_LOAD: begin
        we    = room;
        waddr = count_r[IW-1:0];
        wdata = in_ext;
      end
      OP_BUILD_NODE: begin
        rea     = 1'b1;
        raddr_a = i_dec[IW-1:0];
      end
      OP_SIFT_RD: begin
        rea     = left_in;
        raddr_a = left_idx[IW-1:0];
        reb     = right_in;
        raddr_b = right_idx[IW-1:0];
      end
      OP_SIFT_STEP: begin
        we    = 1'b1;
        waddr = node_r;
        wdata = sel_r ? rdb_r : big_l;
      end
      OP_EXT_RD: begin
        rea     = 1'b1;
        raddr_a = '0;
        reb     = 1'b1;
        raddr_b = i_r[IW-1:0];
      end
      OP_EXT_WR: begin
        we    = 1'b1;
        waddr = i_r[IW-1:0];
        wdata = rda_r;
      end
      OP_OUT_RD: begin
        rea     = 1'b1;
        raddr_a = i_r[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rea) begin
      rda_r <= mem[raddr_a];
    end
    if (reb) begin
      rdb_r <= mem[raddr_b];
    end
  end

  // Control state: fill count, overflow flag, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (op == OP_LOAD) begin
        if (room) begin
          count_r <= count_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (op == OP_OUT_LD) begin
        out_valid_r <= 1'b1;
        if (status.out_final) begin
          count_r <= '0;
          ovf_r   <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers of the sort and the output payload.
  always_ff @(posedge clk) begin
    unique case (op)
      OP_BUILD_INIT: begin
        i_r    <= count_r >> 1;
        live_r <= count_r;
      end
      OP_BUILD_NODE: begin
        i_r    <= i_dec;
        node_r <= i_dec[IW-1:0];
      end
      OP_TAKE_CUR: begin
        cur_r <= rda_r;
      end
      OP_SIFT_STEP: begin
        if (sel_r) begin
          node_r <= right_idx[IW-1:0];
        end else if (sel_l) begin
          node_r <= left_idx[IW-1:0];
        end
      end
      OP_EXT_INIT: begin
        i_r <= count_r - CW'(1);
      end
      OP_EXT_WR: begin
        cur_r  <= rdb_r;
        node_r <= '0;
        live_r <= i_r;
        i_r    <= i_dec;
      end
      OP_OUT_INIT: begin
        i_r <= '0;
      end
      OP_OUT_LD: begin
        out_value_r <= out_conv;
        out_last_r  <= status.out_final;
        out_ovf_r   <= ovf_r;
        i_r         <= i_r + CW'(1);
      end
      default: begin
      end
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

endmodule

// ===== hw/rtl/heap_sorter.sv =====
// Heap sorter top level: input and result channels around controller and datapath.
//
// Values arrive one request per cycle and are appended to a store of DEPTH
// entries; values beyond DEPTH are dropped and every result of that run
// carries out_overflow. The request marked in_last starts the sort: the
// stored n values are built into a binary max-heap and the root is
// repeatedly swapped to the end and sifted down, after which the n values
// leave in ascending order with out_last on the final one. Input is not
// taken from the last request until the final result has entered the output
// register. The build makes n/2 sifts and the extraction n-1; each sift
// visits one node more than the heap levels it walks (at most log2(n)
// levels), and every sift step goes through the single store with two read
// ports and one write port. Readout holds while the output register is full
// and the sink is not ready. Stored values are in_value cut or zero-extended
// to VALUE_BITS bits; results show the stored values cut or zero-extended to
// 32 bits.
module heap_sorter import hs_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  hs_in_if.sink      in_ch,
  hs_out_if.source   out_ch
);

  hs_op_t     op;
  hs_status_t status;

  // Sequence the phases: load, build, extract, read out.
  hs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.in_last),
    .in_ready (in_ch.ready),
    .status   (status),
    .op       (op)
  );

  // Hold the store, the sift compare and the output register.
  hs_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (op),
    .in_value     (in_ch.in_value),
    .out_ready    (out_ch.ready),
    .status       (status),
    .out_valid    (out_ch.valid),
    .out_value    (out_ch.out_value),
    .out_last     (out_ch.out_last),
    .out_overflow (out_ch.out_overflow)
  );

endmodule

// ===== hw/rtl/hs_checker.sv =====
// Port-level checks of the heap sorter and their binding to the top level.
module hs_checker import hs_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_last,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [PORT_BITS-1:0] out_value,
  input logic                 out_last
);

  logic                 in_run_r;
  logic [PORT_BITS-1:0] prev_r;

  // Track the last value taken within the current run.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      in_run_r <= !out_last;
      prev_r   <= out_value;
    end
  end

  // The last request closes the input; the design keeps it closed until its run is sorted.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input still open after last request");

  // Results of a run come in ascending order.
  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && in_run_r |-> out_value >= prev_r)
    else $error("results out of order");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind heap_sorter hs_checker u_hs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.in_last),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.out_value),
  .out_last  (out_ch.out_last)
);
